// File: hdl/vgde_pkg.sv
// Shared types and constants of the volume grayscale dilate/erode block.
package vgde_pkg;

  // Width of the configuration write data (widest register).
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_LO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_HI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 3'd5;

  // The mask always covers a 5x5x5 window, whatever part of it is used.
  localparam int MASK_BITS   = 125;
  localparam int MASK_HI_W   = 61;
  localparam int SIZE_Z_W    = 16;

  // Result queue depth and the cycles the derived sizes need to settle.
  localparam int RES_DEPTH     = 8;
  localparam int SETTLE_CYCLES = 3;

  typedef struct packed {
    logic        func;
    logic [15:0] voxel;
  } vox_t;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } res_t;

endpackage

// File: hdl/vgde_delay.sv
// Variable-length delay line in a ring memory, advanced once per shift.
module vgde_delay #(
  parameter int AW = 7,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic [DW-1:0] din,
  input  logic [AW:0]   len,
  output logic [DW-1:0] dout
);

  logic [DW-1:0] mem [2**AW];
  logic [AW-1:0] wp;
  logic [AW:0]   rsum;
  logic [AW-1:0] raddr;
  logic          fwd;

  // The read always fetches the value that the next shift will hand on.
  assign rsum  = {1'b0, wp} + (AW+1)'(shift) - len;
  assign raddr = rsum[AW-1:0];
  assign fwd   = shift && (len == (AW+1)'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (shift) begin
      wp <= wp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      mem[wp] <= din;
    end
    dout <= fwd ? din : mem[raddr];
  end

endmodule

// File: hdl/vgde_plane.sv
// One slice plane of the window: line delays, tap rows and the slice delay.
module vgde_plane #(
  parameter int R   = 2,
  parameter int VB  = 16,
  parameter int LAW = 7,
  parameter int SAW = 14
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic [VB-1:0] pin,
  input  logic [LAW:0]  line_len,
  input  logic [SAW:0]  slice_len,
  output logic [VB-1:0] taps [2*R+1][2*R+1],
  output logic [VB-1:0] pout
);

  localparam int W2 = 2 * R + 1;

  logic [VB-1:0] line_out [2*R];
  logic [VB-1:0] row_in [W2];

  for (genvar i = 0; i < 2 * R; i++) begin : g_line
    vgde_delay #(.AW(LAW), .DW(VB)) u_line (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .din   ((i == 0) ? pin : line_out[(i == 0) ? 0 : i - 1]),
      .len   (line_len),
      .dout  (line_out[i])
    );
  end

  // The top row takes the plane input, each lower row one more line back.
  for (genvar j = 0; j < W2; j++) begin : g_rowin
    if (j == W2 - 1) begin : g_top
      assign row_in[j] = pin;
    end else begin : g_low
      assign row_in[j] = line_out[2*R-1-j];
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int j = 0; j < W2; j++) begin
        for (int i = 0; i < W2 - 1; i++) begin
          taps[j][i] <= taps[j][i+1];
        end
        taps[j][W2-1] <= row_in[j];
      end
    end
  end

  vgde_delay #(.AW(SAW), .DW(VB)) u_slice (
    .clk   (clk),
    .rst   (rst),
    .shift (shift),
    .din   (pin),
    .len   (slice_len),
    .dout  (pout)
  );

endmodule

// File: hdl/vgde_reduce.sv
// Masked, bounds-checked maximum or minimum over the window, as a pipeline.
module vgde_reduce #(
  parameter int R    = 2,
  parameter int VB   = 16,
  parameter int SX_W = 8,
  parameter int SY_W = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [SX_W-1:0]               cx,
  input  logic [SY_W-1:0]               cy,
  input  logic [vgde_pkg::SIZE_Z_W-1:0] cz,
  input  logic                          last_in,
  input  logic                          mode,
  input  logic [vgde_pkg::MASK_BITS-1:0] mask,
  input  logic [SX_W-1:0]               sx,
  input  logic [SY_W-1:0]               sy,
  input  logic [vgde_pkg::SIZE_Z_W-1:0] sz,
  input  logic [VB-1:0]                 taps [2*R+1][2*R+1][2*R+1],
  output logic                          valid_o,
  output logic [VB-1:0]                 value_o,
  output logic                          last_o
);

  localparam int W2 = 2 * R + 1;
  localparam int ZW = vgde_pkg::SIZE_Z_W;

  logic          xok [W2];
  logic          yok [W2];
  logic          zok [W2];
  logic [VB-1:0] ident;
  logic [VB-1:0] v0 [W2][W2][W2];
  logic [VB-1:0] v1 [W2][W2];
  logic [VB-1:0] v2 [W2];
  logic [VB-1:0] v1_n [W2][W2];
  logic [VB-1:0] v2_n [W2];
  logic [VB-1:0] v3_n;
  logic [2:0]    vld;
  logic [2:0]    lst;

  function automatic logic [VB-1:0] pick(input logic m, input logic [VB-1:0] a,
                                         input logic [VB-1:0] b);
    logic lt;
    lt = a < b;
    return m ? (lt ? a : b) : (lt ? b : a);
  endfunction

  assign ident = mode ? '1 : '0;

  for (genvar i = 0; i < W2; i++) begin : g_axis
    localparam int D = i - R;
    if (D < 0) begin : g_neg
      assign xok[i] = cx >= SX_W'(-D);
      assign yok[i] = cy >= SY_W'(-D);
      assign zok[i] = cz >= ZW'(-D);
    end else begin : g_pos
      assign xok[i] = ({1'b0, cx} + (SX_W+1)'(D)) < {1'b0, sx};
      assign yok[i] = ({1'b0, cy} + (SY_W+1)'(D)) < {1'b0, sy};
      assign zok[i] = ({1'b0, cz} + (ZW+1)'(D)) < {1'b0, sz};
    end
  end

  // Disabled or outside taps are replaced by the identity of the operation; the centre tap is always used.
  for (genvar k = 0; k < W2; k++) begin : g_z
    for (genvar j = 0; j < W2; j++) begin : g_y
      for (genvar i = 0; i < W2; i++) begin : g_x
        localparam int B = (k - R + 2) * 25 + (j - R + 2) * 5 + (i - R + 2);
        localparam bit CTR = (i == R) && (j == R) && (k == R);
        logic en;
        assign en = CTR || (mask[B] && xok[i] && yok[j] && zok[k]);
        always_ff @(posedge clk) begin
          v0[k][j][i] <= en ? taps[k][j][i] : ident;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < W2; k++) begin
      for (int j = 0; j < W2; j++) begin
        v1_n[k][j] = v0[k][j][0];
        for (int i = 1; i < W2; i++) begin
          v1_n[k][j] = pick(mode, v1_n[k][j], v0[k][j][i]);
        end
      end
    end
    for (int k = 0; k < W2; k++) begin
      v2_n[k] = v1[k][0];
      for (int j = 1; j < W2; j++) begin
        v2_n[k] = pick(mode, v2_n[k], v1[k][j]);
      end
    end
    v3_n = v2[0];
    for (int k = 1; k < W2; k++) begin
      v3_n = pick(mode, v3_n, v2[k]);
    end
  end

  always_ff @(posedge clk) begin
    v1      <= v1_n;
    v2      <= v2_n;
    value_o <= v3_n;
    lst     <= {lst[1:0], last_in};
    last_o  <= lst[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      valid_o <= 1'b0;
    end else begin
      vld     <= {vld[1:0], start};
      valid_o <= vld[2];
    end
  end

endmodule

// File: hdl/volume_grayscale_dilate_erode_core.sv
// Top level of the 3D grayscale dilate/erode block.
// Voxels enter in raster order (x fastest, then y, then z) at up to one per cycle and flow
// through a chain of slice planes, each with line delays, rows of window taps and a slice
// delay, so the whole neighbourhood of the window centre sits in registers. A result for a
// voxel is offered after the request completing its neighbourhood has passed through the
// launch register, the reduction pipeline and the result queue; the sustained rate is one
// voxel per cycle, held back only by a stalled result side. After the final voxel of a
// volume the window drains with pad requests, one result per request; a new volume is
// taken only once the drain is complete. After reset, and after any register write, no
// request is taken while the derived sizes settle.
module volume_grayscale_dilate_erode_core #(
  parameter int MAX_X      = 128,
  parameter int MAX_Y      = 128,
  parameter int WINDOW     = 5,
  parameter int VOXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vox_valid,
  output logic                                vox_stall,
  input  vgde_pkg::vox_t                      vox,
  output logic                                res_valid,
  input  logic                                res_stall,
  output vgde_pkg::res_t                      res,
  input  logic                                cfg_we,
  input  logic [vgde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vgde_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int R      = WINDOW / 2;
  localparam int W2     = 2 * R + 1;
  localparam int VB     = (VOXEL_BITS < 16) ? VOXEL_BITS : 16;
  localparam int SX_MAX = (MAX_X < 255) ? MAX_X : 255;
  localparam int SY_MAX = (MAX_Y < 255) ? MAX_Y : 255;
  localparam int SX_W   = $clog2(SX_MAX + 1);
  localparam int SY_W   = $clog2(SY_MAX + 1);
  localparam int ZW     = vgde_pkg::SIZE_Z_W;
  localparam int S_W    = SX_W + SY_W;
  localparam int T_W    = S_W + ZW;
  localparam int C_W    = T_W + 1;
  localparam int LAW    = $clog2(SX_MAX);
  localparam int SAW    = $clog2(SX_MAX * SY_MAX);
  localparam int DEPTH  = vgde_pkg::RES_DEPTH;
  localparam int PW     = $clog2(DEPTH);
  localparam int OW     = $clog2(DEPTH + 1);

  // Registers.
  logic                           mode;
  logic [63:0]                    mask_lo;
  logic [vgde_pkg::MASK_HI_W-1:0] mask_hi;
  logic [7:0]                     size_x;
  logic [7:0]                     size_y;
  logic [ZW-1:0]                  size_z;
  logic [1:0]                     settle;

  // Derived sizes.
  logic [SX_W-1:0] sx;
  logic [SY_W-1:0] sy;
  logic [ZW-1:0]   sz;
  logic [S_W-1:0]  slice;
  logic [T_W-1:0]  total;
  logic [C_W-1:0]  lag;

  // Positions.
  logic [T_W-1:0]  in_pos;
  logic [T_W-1:0]  out_pos;
  logic [C_W-1:0]  shift_cnt;
  logic [SX_W-1:0] nc_x;
  logic [SY_W-1:0] nc_y;
  logic [ZW-1:0]   nc_z;

  // Launch register.
  logic            l_valid;
  logic [SX_W-1:0] l_x;
  logic [SY_W-1:0] l_y;
  logic [ZW-1:0]   l_z;
  logic            l_last;

  // Result queue.
  vgde_pkg::res_t  fifo [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [OW-1:0]   fifo_cnt;
  logic [OW-1:0]   occ;

  logic            size_wr;
  logic            acc;
  logic            out_acc;
  logic            vol_done;
  logic [T_W-1:0]  in_b;
  logic [T_W-1:0]  out_b;
  logic            wr;
  logic [T_W-1:0]  in_n;
  logic [C_W-1:0]  reach;
  logic [C_W-1:0]  tm1;
  logic [C_W-1:0]  need;
  logic            emit;
  logic            restart;
  logic [C_W-1:0]  sc_b;
  logic            all_in;
  logic            flush;
  logic            shift;
  logic            launch;
  logic            busy;
  logic [VB-1:0]   sval;
  logic            last_c;

  logic [VB-1:0]   taps [W2][W2][W2];
  logic [VB-1:0]   pin [W2];
  logic [VB-1:0]   pout [W2];
  logic            r_valid;
  logic [VB-1:0]   r_value;
  logic            r_last;

  assign size_wr = cfg_we && (cfg_index == vgde_pkg::CFG_SIZE_X ||
                              cfg_index == vgde_pkg::CFG_SIZE_Y ||
                              cfg_index == vgde_pkg::CFG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= 1'b0;
      mask_lo <= '0;
      mask_hi <= '0;
      size_x  <= 8'd128;
      size_y  <= 8'd128;
      size_z  <= ZW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        vgde_pkg::CFG_MODE:    mode    <= cfg_data[0];
        vgde_pkg::CFG_MASK_LO: mask_lo <= cfg_data;
        vgde_pkg::CFG_MASK_HI: mask_hi <= cfg_data[vgde_pkg::MASK_HI_W-1:0];
        vgde_pkg::CFG_SIZE_X:  size_x  <= cfg_data[7:0];
        vgde_pkg::CFG_SIZE_Y:  size_y  <= cfg_data[7:0];
        vgde_pkg::CFG_SIZE_Z:  size_z  <= cfg_data[ZW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      settle <= 2'(vgde_pkg::SETTLE_CYCLES);
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // Sizes are clamped into range, then the slice area, volume and lag follow.
  always_ff @(posedge clk) begin
    if (size_x == 8'd0) begin
      sx <= SX_W'(1);
    end else if (size_x > 8'(SX_MAX)) begin
      sx <= SX_W'(SX_MAX);
    end else begin
      sx <= SX_W'(size_x);
    end
    if (size_y == 8'd0) begin
      sy <= SY_W'(1);
    end else if (size_y > 8'(SY_MAX)) begin
      sy <= SY_W'(SY_MAX);
    end else begin
      sy <= SY_W'(size_y);
    end
    sz    <= (size_z == '0) ? ZW'(1) : size_z;
    slice <= sx * sy;
    total <= slice * sz;
    lag   <= C_W'(R) * C_W'(slice) + C_W'(R) * C_W'(sx) + C_W'(R);
  end

  assign acc     = vox_valid && !vox_stall;
  assign out_acc = res_valid && !res_stall;

  always_comb begin
    vol_done = out_pos >= total;
    in_b     = vol_done ? '0 : in_pos;
    out_b    = vol_done ? '0 : out_pos;
    wr       = acc && !vox.func && (in_b < total);
    in_n     = in_b + T_W'(wr);
    reach    = {1'b0, out_b} + lag;
    tm1      = {1'b0, total} - C_W'(1);
    need     = (reach > tm1) ? tm1 : reach;
    emit     = acc && ({1'b0, in_n} > need);
    restart  = acc && vol_done;
    sc_b     = restart ? '0 : shift_cnt;
    all_in   = in_pos == total;
    // Once every voxel is in, the window keeps moving only as far as results are owed.
    flush    = !wr && !restart && all_in && (settle == 2'd0) && (occ < OW'(DEPTH)) &&
               ((shift_cnt + C_W'(1)) <= ({1'b0, out_pos} + lag));
    shift    = wr || flush;
    launch   = shift && (sc_b >= lag);
    busy     = vol_done && (shift_cnt != ({1'b0, total} + lag));
    sval     = wr ? vox.voxel[VB-1:0] : '0;
    last_c   = (nc_x == sx - 1'b1) && (nc_y == sy - 1'b1) && (nc_z == sz - 1'b1);
  end

  assign vox_stall = (settle != 2'd0) || busy || (occ >= OW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst || size_wr) begin
      in_pos    <= '0;
      out_pos   <= '0;
      shift_cnt <= '0;
      nc_x      <= '0;
      nc_y      <= '0;
      nc_z      <= '0;
    end else begin
      if (acc) begin
        in_pos  <= in_n;
        out_pos <= out_b + T_W'(emit);
      end
      shift_cnt <= sc_b + C_W'(shift);
      if (launch) begin
        if (nc_x == sx - 1'b1) begin
          nc_x <= '0;
          if (nc_y == sy - 1'b1) begin
            nc_y <= '0;
            nc_z <= nc_z + 1'b1;
          end else begin
            nc_y <= nc_y + 1'b1;
          end
        end else begin
          nc_x <= nc_x + 1'b1;
        end
      end else if (restart) begin
        nc_x <= '0;
        nc_y <= '0;
        nc_z <= '0;
      end
    end
  end

  // A restart and a launch never meet: the first launch of a volume waits for the lag.
  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else begin
      l_valid <= launch;
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      l_x    <= nc_x;
      l_y    <= nc_y;
      l_z    <= nc_z;
      l_last <= last_c;
    end
  end

  for (genvar k = 0; k < W2; k++) begin : g_plane
    if (k == W2 - 1) begin : g_head
      assign pin[k] = sval;
    end else begin : g_tail
      assign pin[k] = pout[k+1];
    end
    vgde_plane #(.R(R), .VB(VB), .LAW(LAW), .SAW(SAW)) u_plane (
      .clk       (clk),
      .rst       (rst),
      .shift     (shift),
      .pin       (pin[k]),
      .line_len  ((LAW+1)'(sx)),
      .slice_len ((SAW+1)'(slice)),
      .taps      (taps[k]),
      .pout      (pout[k])
    );
  end

  vgde_reduce #(.R(R), .VB(VB), .SX_W(SX_W), .SY_W(SY_W)) u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (l_valid),
    .cx      (l_x),
    .cy      (l_y),
    .cz      (l_z),
    .last_in (l_last),
    .mode    (mode),
    .mask    ({mask_hi, mask_lo}),
    .sx      (sx),
    .sy      (sy),
    .sz      (sz),
    .taps    (taps),
    .valid_o (r_valid),
    .value_o (r_value),
    .last_o  (r_last)
  );

  always_ff @(posedge clk) begin
    if (r_valid) begin
      fifo[wr_ptr] <= '{value: 16'(r_value), last: r_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
      occ      <= '0;
    end else begin
      if (r_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_acc) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + OW'(r_valid) - OW'(out_acc);
      occ      <= occ + OW'(launch) - OW'(out_acc);
    end
  end

  assign res_valid = fifo_cnt != '0;
  assign res       = fifo[rd_ptr];

`ifndef SYNTH
  a_res_counted: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> occ != '0)
    else $error("result offered with no launch outstanding");

  a_queue_within_occ: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= occ)
    else $error("result queue holds more than was launched");

  a_launch_counts: assert property (@(posedge clk) disable iff (rst)
    launch && !out_acc |=> occ == $past(occ) + 1'b1)
    else $error("launch not counted in occupancy");

  a_flush_after_input: assert property (@(posedge clk) disable iff (rst)
    flush |-> all_in && !wr)
    else $error("window drained before the volume was complete");
`endif

endmodule
